// File: hw/rtl/csvfs_pkg.sv
// Package for the CSV record and field splitter.
// Holds the result kind codes, character constants and the command record
// passed from the front end to the back end. No dependencies.
package csvfs_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FEND  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] last;
    logic             line_end;
    logic             header_row;
    logic             too_many;
  } cmd_t;

endpackage

// File: hw/rtl/csvfs_in_if.sv
// Input channel interface of the CSV record and field splitter.
// Carries valid, ready and one stream byte with its end-of-input mark.
// Depends on nothing.
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: hw/rtl/csvfs_out_if.sv
// Result channel interface of the CSV record and field splitter.
// Carries valid, ready and one result item. Depends on nothing.
interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [5:0] field_index;
  logic       header_row;
  logic       padded;
  logic       row_end;
  logic       too_many_fields;

  modport source (output valid, output kind, output out_byte, output field_index,
                  output header_row, output padded, output row_end,
                  output too_many_fields, input ready);
  modport sink (input valid, input kind, input out_byte, input field_index,
                input header_row, input padded, input row_end,
                input too_many_fields, output ready);
endinterface

// File: hw/rtl/csvfs_front.sv
// Front end of the CSV splitter: takes one byte per transaction, tracks
// quoting, line and field state and pushes at most one command per byte.
// Depends on csvfs_pkg and csvfs_in_if.
module csvfs_front #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  csvfs_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             push,
  output csvfs_pkg::cmd_t  cmd
);
  import csvfs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FIELDS - 1);

  typedef enum logic [2:0] {
    QM_PLAIN  = 3'b001,
    QM_QUOTED = 3'b010,
    QM_QPEND  = 3'b100
  } qmode_t;

  typedef enum logic [2:0] {
    LC_NONE  = 3'b001,
    LC_CR    = 3'b010,
    LC_OTHER = 3'b100
  } lclass_t;

  qmode_t           qm_r, qm_nxt;
  lclass_t          lc_r, lc_nxt;
  logic             hs_r, hs_nxt;
  logic [IDX_W-1:0] hdr_last_r, hdr_last_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic             ovf_r, ovf_nxt;
  logic             cmd_vld;
  logic             accept;
  logic             unq;
  logic             end_line;
  logic [7:0]       c;

  assign c            = in_ch.in_byte;
  assign in_ch.ready  = ~q_full;
  assign accept       = in_ch.valid & in_ch.ready;
  assign push         = accept & cmd_vld;

  always_comb begin
    qm_nxt         = qm_r;
    lc_nxt         = lc_r;
    hs_nxt         = hs_r;
    hdr_last_nxt   = hdr_last_r;
    cur_nxt        = cur_r;
    ovf_nxt        = ovf_r;
    cmd_vld        = 1'b0;
    unq            = 1'b0;
    end_line       = 1'b0;
    cmd.kind       = KIND_BYTE;
    cmd.data       = 8'd0;
    cmd.idx        = cur_r;
    cmd.last       = cur_r;
    cmd.line_end   = 1'b0;
    cmd.header_row = ~hs_r;
    cmd.too_many   = ovf_r;

    if (in_ch.end_of_input) begin
      if (!hs_r && lc_r == LC_NONE) begin
        cmd_vld  = 1'b1;
        cmd.kind = KIND_EMPTY;
      end else begin
        end_line = 1'b1;
      end
    end else if (c == CH_LF) begin
      end_line = 1'b1;
    end else begin
      lc_nxt = (lc_r == LC_NONE && c == CH_CR) ? LC_CR : LC_OTHER;
      case (qm_r)
        QM_QUOTED: begin
          if (c == CH_QUOTE) begin
            qm_nxt = QM_QPEND;
          end else begin
            cmd_vld  = 1'b1;
            cmd.data = c;
          end
        end
        QM_QPEND: begin
          if (c == CH_QUOTE) begin
            cmd_vld  = 1'b1;
            cmd.data = CH_QUOTE;
            qm_nxt   = QM_QUOTED;
          end else begin
            qm_nxt = QM_PLAIN;
            unq    = 1'b1;
          end
        end
        default: begin
          qm_nxt = QM_PLAIN;
          unq    = 1'b1;
        end
      endcase
      if (unq) begin
        if (c == CH_QUOTE) begin
          qm_nxt = QM_QUOTED;
        end else if (c == CH_COMMA) begin
          cmd_vld  = 1'b1;
          cmd.kind = KIND_FEND;
          if (cur_r == LAST_IDX) begin
            ovf_nxt = 1'b1;
          end else begin
            cur_nxt = cur_r + IDX_W'(1);
          end
        end else if (c != CH_CR) begin
          cmd_vld  = 1'b1;
          cmd.data = c;
        end
      end
    end

    if (end_line) begin
      if (!(hs_r && (lc_r == LC_NONE || lc_r == LC_CR))) begin
        cmd_vld      = 1'b1;
        cmd.kind     = KIND_FEND;
        cmd.line_end = 1'b1;
        if (hs_r) begin
          cmd.last = (hdr_last_r > cur_r) ? hdr_last_r : cur_r;
        end else begin
          hdr_last_nxt = cur_r;
          hs_nxt       = 1'b1;
        end
      end
      qm_nxt  = QM_PLAIN;
      lc_nxt  = LC_NONE;
      cur_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (in_ch.end_of_input) begin
      hs_nxt       = 1'b0;
      hdr_last_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r       <= QM_PLAIN;
      lc_r       <= LC_NONE;
      hs_r       <= 1'b0;
      hdr_last_r <= '0;
      cur_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (accept) begin
      qm_r       <= qm_nxt;
      lc_r       <= lc_nxt;
      hs_r       <= hs_nxt;
      hdr_last_r <= hdr_last_nxt;
      cur_r      <= cur_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

// File: hw/rtl/csvfs_queue.sv
// Short command queue between the front and back ends of the CSV splitter.
// Four entries held in registers. Depends on csvfs_pkg.
module csvfs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  csvfs_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_vld,
  output csvfs_pkg::cmd_t  head
);
  import csvfs_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_r];
  assign do_pop   = pop & head_vld;

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/csvfs_back.sv
// Back end of the CSV splitter: turns queued commands into result
// transactions, expanding a line end into the padding burst, behind an
// output register. Depends on csvfs_pkg and csvfs_out_if.
module csvfs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  csvfs_pkg::cmd_t  head,
  output logic             pop,
  csvfs_out_if.source      out_ch
);
  import csvfs_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] pos;
  logic             load;
  logic             emit;
  logic             done;
  logic             out_valid_r;
  kind_t            kind_r;
  logic [7:0]       byte_r;
  logic [IDX_W-1:0] idx_r;
  logic             hdr_r;
  logic             pad_r;
  logic             rend_r;
  logic             tmf_r;

  assign load = ~out_valid_r | out_ch.ready;
  assign emit = load & head_vld;
  assign pos  = busy_r ? pos_r : head.idx;
  assign done = ~head.line_end | (pos == head.last);
  assign pop  = emit & done;

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (emit) begin
      busy_nxt = ~done;
      pos_nxt  = pos + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      if (load) begin
        out_valid_r <= head_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= head.kind;
      byte_r <= head.data;
      idx_r  <= pos;
      hdr_r  <= head.header_row;
      pad_r  <= busy_r;
      rend_r <= head.line_end & (pos == head.last);
      tmf_r  <= head.too_many;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.out_byte        = byte_r;
  assign out_ch.field_index     = idx_r;
  assign out_ch.header_row      = hdr_r;
  assign out_ch.padded          = pad_r;
  assign out_ch.row_end         = rend_r;
  assign out_ch.too_many_fields = tmf_r;

endmodule

// File: hw/rtl/csv_record_field_splitter.sv
// The splitter takes one CSV byte per cycle until its command queue fills and
// answers with field content bytes, end-of-field marks and an empty-input
// report; the first record is taken as the header and later short rows are
// padded with empty fields up to its field count. The front end classifies each
// byte and queues at most one command for it. A line end on a short data row
// yields one result per cycle, while results are taken, for each field up to
// the header count from the back end; the input stalls only when the four-entry
// command queue fills, as during such a burst or while results are held off.
// A byte's first result passes through the queue and then the output register.
// Depends on csvfs_pkg, csvfs_in_if, csvfs_out_if and the csvfs front,
// queue and back modules.
module csv_record_field_splitter #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  csvfs_in_if.sink     in_ch,
  csvfs_out_if.source  out_ch
);
  import csvfs_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic head_vld;

  csvfs_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .cmd    (push_cmd)
  );

  csvfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head_vld (head_vld),
    .head     (head)
  );

  csvfs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  a_pad_is_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.padded |-> out_ch.kind == KIND_FEND && out_ch.field_index != '0)
    else $error("padded result is not a later end of field");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_EMPTY |->
      !out_ch.padded && !out_ch.row_end && out_ch.out_byte == 8'd0)
    else $error("empty input report carries field data");

  a_rowend_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.row_end |-> out_ch.kind == KIND_FEND)
    else $error("row end on a result that is not an end of field");

endmodule
